@@ src/ilcws_pkg.sv @@
package ilcws_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_Q_RD,
    ST_Q_MUL,
    ST_Q_ACC,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  localparam logic OP_MIX = 1'b0;
  localparam logic OP_COV = 1'b1;
  localparam logic [1:0] STOKES_U = 2'd2;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic        operation;
    logic [1:0]  stokes;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last_entry;
    logic [25:0] pixel_tag;
  } load_t;

  typedef struct packed {
    logic [1:0]  weight_stokes;
    logic [2:0]  band;
    logic [31:0] weight;
    logic        divide_fault;
    logic [25:0] pixel_tag_out;
    logic        last;
  } result_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] floor_shr16_sat32(input logic signed [63:0] x);
    logic signed [47:0] t;
    t = 48'(x >>> 16);
    if (t[47:31] == {17{t[47]}}) begin
      return t[31:0];
    end
    return t[47] ? NEG_MAX : POS_MAX;
  endfunction

endpackage

@@ src/ilcws_if.sv @@
interface ilcws_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  stokes;
  logic [2:0]  row;
  logic [2:0]  col;
  logic signed [31:0] value;
  logic        last_entry;
  logic [25:0] pixel_tag;
  modport source (output valid, operation, stokes, row, col, value, last_entry, pixel_tag,
                  input ready);
  modport sink (input valid, operation, stokes, row, col, value, last_entry, pixel_tag,
                output ready);
endinterface

interface ilcws_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  weight_stokes;
  logic [2:0]  band;
  logic signed [31:0] weight;
  logic        divide_fault;
  logic [25:0] pixel_tag_out;
  logic        last;
  modport source (output valid, weight_stokes, band, weight, divide_fault, pixel_tag_out, last,
                  input ready);
  modport sink (input valid, weight_stokes, band, weight, divide_fault, pixel_tag_out, last,
                output ready);
endinterface

@@ src/ilcws_div.sv @@
module ilcws_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic [31:0]        weight
);

  localparam logic [31:0] POS_MAX_W = ilcws_pkg::POS_MAX;

  logic [79:0] dvd_r;
  logic [64:0] rem_r;
  logic [63:0] qm_r;
  logic [31:0] q_r;
  logic        ovf_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [64:0] rem_sh;
  logic        ge;
  logic [32:0] mag;
  logic [63:0] nm;
  logic [63:0] dm;

  assign nm     = num[63] ? 64'(-num) : 64'(num);
  assign dm     = den[63] ? 64'(-den) : 64'(den);
  assign rem_sh = {rem_r[63:0], dvd_r[79]};
  assign ge     = rem_sh >= {1'b0, qm_r};
  assign mag    = ovf_r ? 33'h1_0000_0000 : {1'b0, q_r};

  always_comb begin
    if (!neg_r) begin
      weight = (mag > {1'b0, POS_MAX_W}) ? POS_MAX_W : mag[31:0];
    end else begin
      weight = (mag > {1'b0, ilcws_pkg::NEG_MAX}) ? ilcws_pkg::NEG_MAX : 32'(-mag[31:0]);
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {nm, 16'd0};
      qm_r  <= dm;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= num[63] != den[63];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[78:0], 1'b0};
      rem_r <= ge ? 65'(rem_sh - {1'b0, qm_r}) : rem_sh;
      q_r   <= {q_r[30:0], ge};
      ovf_r <= ovf_r | q_r[31];
    end
  end

endmodule

@@ src/ilcws_engine.sv @@
module ilcws_engine #(
  parameter int MB = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  input  ilcws_pkg::load_t      load,
  output logic                  load_ready,
  input  logic [3:0]            bands_in_use,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ilcws_pkg::result_t    res
);

  localparam int BW = $clog2(MB);
  localparam int NW = $clog2(MB + 1);
  localparam int CD = 3 * MB * MB;
  localparam int AW = $clog2(CD);

  ilcws_pkg::state_t state_r, state_nxt;

  logic signed [31:0] mix_mem [MB];
  logic signed [31:0] cov_mem [CD];
  logic signed [31:0] mix_rd_r;
  logic signed [31:0] cov_rd_r;
  logic [BW-1:0]      mix_raddr;
  logic [AW-1:0]      cov_raddr;
  logic [AW-1:0]      cov_waddr;

  logic [1:0]         c_r;
  logic [BW-1:0]      b_r;
  logic [BW-1:0]      j_r;
  logic [NW-1:0]      n_r;
  logic [NW-1:0]      n_nxt;
  logic signed [63:0] acc_r;
  logic signed [63:0] acc_sum;
  logic signed [63:0] quad_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] num_r [MB];
  logic [25:0]        tag_r;
  logic [31:0]        w_r;
  logic               fault_r;

  logic               start;
  logic               j_end;
  logic               b_end;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_weight;

  assign start   = load_valid && load_ready && load.operation == ilcws_pkg::OP_COV &&
                   load.last_entry;
  assign j_end   = NW'(j_r) == n_r - NW'(1);
  assign b_end   = NW'(b_r) == n_r - NW'(1);
  assign acc_sum = ilcws_pkg::sat_add64(acc_r, prod_r);
  assign cov_waddr = AW'(32'(load.stokes) * MB * MB + 32'(load.row) * MB + 32'(load.col));

  always_comb begin
    if (bands_in_use == 4'd0) begin
      n_nxt = NW'(1);
    end else if (32'(bands_in_use) > MB) begin
      n_nxt = NW'(MB);
    end else begin
      n_nxt = NW'(bands_in_use);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ilcws_pkg::ST_IDLE:      if (start) state_nxt = ilcws_pkg::ST_MAC_RD;
      ilcws_pkg::ST_MAC_RD:    state_nxt = ilcws_pkg::ST_MAC_MUL;
      ilcws_pkg::ST_MAC_MUL:   state_nxt = ilcws_pkg::ST_MAC_ACC;
      ilcws_pkg::ST_MAC_ACC:   state_nxt = j_end ? ilcws_pkg::ST_Q_RD : ilcws_pkg::ST_MAC_RD;
      ilcws_pkg::ST_Q_RD:      state_nxt = ilcws_pkg::ST_Q_MUL;
      ilcws_pkg::ST_Q_MUL:     state_nxt = ilcws_pkg::ST_Q_ACC;
      ilcws_pkg::ST_Q_ACC:     state_nxt = b_end ? ilcws_pkg::ST_DIV_START
                                                 : ilcws_pkg::ST_MAC_RD;
      ilcws_pkg::ST_DIV_START: state_nxt = (quad_r == '0) ? ilcws_pkg::ST_EMIT
                                                          : ilcws_pkg::ST_DIV_RUN;
      ilcws_pkg::ST_DIV_RUN:   if (div_done) state_nxt = ilcws_pkg::ST_EMIT;
      ilcws_pkg::ST_EMIT: begin
        if (res_ready) begin
          priority if (!b_end) state_nxt = ilcws_pkg::ST_DIV_START;
          else if (c_r == ilcws_pkg::STOKES_U) state_nxt = ilcws_pkg::ST_IDLE;
          else state_nxt = ilcws_pkg::ST_MAC_RD;
        end
      end
      default: state_nxt = ilcws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load_ready = state_r == ilcws_pkg::ST_IDLE;
    res_valid  = state_r == ilcws_pkg::ST_EMIT;
    div_start  = state_r == ilcws_pkg::ST_DIV_START && quad_r != '0;
    mix_raddr  = (state_r == ilcws_pkg::ST_Q_RD) ? b_r : j_r;
    cov_raddr  = AW'(32'(c_r) * MB * MB + 32'(j_r) * MB + 32'(b_r));
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      if (load.operation == ilcws_pkg::OP_MIX && 32'(load.row) < MB) begin
        mix_mem[BW'(load.row)] <= load.value;
      end
      if (load.operation == ilcws_pkg::OP_COV && load.stokes != 2'd3 &&
          32'(load.row) < MB && 32'(load.col) < MB) begin
        cov_mem[cov_waddr] <= load.value;
      end
    end
    mix_rd_r <= mix_mem[mix_raddr];
    cov_rd_r <= cov_mem[cov_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilcws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ilcws_pkg::ST_IDLE: begin
        c_r    <= '0;
        b_r    <= '0;
        j_r    <= '0;
        acc_r  <= '0;
        quad_r <= '0;
        n_r    <= n_nxt;
        tag_r  <= load.pixel_tag;
      end
      ilcws_pkg::ST_MAC_MUL: prod_r <= 64'(mix_rd_r) * 64'(cov_rd_r);
      ilcws_pkg::ST_MAC_ACC: begin
        acc_r <= acc_sum;
        if (j_end) begin
          num_r[b_r] <= acc_sum;
        end else begin
          j_r <= j_r + BW'(1);
        end
      end
      ilcws_pkg::ST_Q_MUL:
        prod_r <= 64'(mix_rd_r) * 64'(ilcws_pkg::floor_shr16_sat32(acc_r));
      ilcws_pkg::ST_Q_ACC: begin
        quad_r <= ilcws_pkg::sat_add64(quad_r, prod_r);
        acc_r  <= '0;
        j_r    <= '0;
        b_r    <= b_end ? '0 : b_r + BW'(1);
      end
      ilcws_pkg::ST_DIV_START: begin
        w_r     <= '0;
        fault_r <= quad_r == '0;
      end
      ilcws_pkg::ST_DIV_RUN: if (div_done) w_r <= div_weight;
      ilcws_pkg::ST_EMIT: begin
        if (res_ready) begin
          if (b_end) begin
            b_r    <= '0;
            c_r    <= c_r + 2'd1;
            quad_r <= '0;
          end else begin
            b_r <= b_r + BW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.weight_stokes = c_r;
    res.band          = 3'(b_r);
    res.weight        = w_r;
    res.divide_fault  = fault_r;
    res.pixel_tag_out = tag_r;
    res.last          = c_r == ilcws_pkg::STOKES_U && b_end;
  end

  ilcws_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num_r[b_r]),
    .den    (quad_r),
    .done   (div_done),
    .weight (div_weight)
  );

`ifndef SYNTH
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ilcws_pkg::ST_DIV_RUN)
    else $error("divider done outside run");
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ilcws_pkg::ST_IDLE |-> n_r >= NW'(1) && 32'(n_r) <= MB)
    else $error("band count out of range");
  a_last_u: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready && res.last |=> state_r == ilcws_pkg::ST_IDLE)
    else $error("last weight did not end run");
`endif

endmodule

@@ src/ilc_weight_solver_core.sv @@
// ILC weight solver. Mixing and covariance entries load one per cycle while idle; a
// covariance entry with last_entry set starts the solve, during which no request is taken.
// The solve runs each multiply-accumulate as read, multiply and accumulate steps through the
// covariance memory (3*n*n MACs), 3*n for the quadratic forms, and one divide (skipped
// when the quadratic form is zero) plus one emit per weight, for n bands.
// bands_in_use sits at byte address 0; 0 acts as 1, above MAX_BANDS as MAX_BANDS.
module ilc_weight_solver_core #(
  parameter int MAX_BANDS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  ilcws_in_if.sink     in_ch,
  ilcws_out_if.source  out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [3:0]          bands_r;
  ilcws_pkg::load_t    load;
  ilcws_pkg::result_t  res;
  ilcws_pkg::result_t  out_r;
  logic                out_valid_r;
  logic                res_valid;
  logic                res_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {28'd0, bands_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bands_r <= 4'd8;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      bands_r <= cfg_pwdata[3:0];
    end
  end

  always_comb begin
    load.operation  = in_ch.operation;
    load.stokes     = in_ch.stokes;
    load.row        = in_ch.row;
    load.col        = in_ch.col;
    load.value      = in_ch.value;
    load.last_entry = in_ch.last_entry;
    load.pixel_tag  = in_ch.pixel_tag;
  end

  ilcws_engine #(.MB(MAX_BANDS)) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (in_ch.valid),
    .load         (load),
    .load_ready   (in_ch.ready),
    .bands_in_use (bands_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.weight_stokes = out_r.weight_stokes;
  assign out_ch.band          = out_r.band;
  assign out_ch.weight        = out_r.weight;
  assign out_ch.divide_fault  = out_r.divide_fault;
  assign out_ch.pixel_tag_out = out_r.pixel_tag_out;
  assign out_ch.last          = out_r.last;

endmodule

@@ test/ilcws_checker.sv @@
`timescale 1ns / 100ps
module ilcws_checker #(
  parameter int MAX_BANDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ilcws_in_if         in_ch,
  ilcws_out_if        out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          errors,
  output int          pending
);

  localparam int NUM_STOKES = 3;
  localparam logic [2:0] ADDR_BANDS = 3'd0;

  logic signed [63:0] mix_vec [MAX_BANDS];
  logic signed [63:0] inv_cov [NUM_STOKES][MAX_BANDS][MAX_BANDS];
  logic [3:0]         bands_reg;
  ilcws_pkg::result_t weights_due[$];

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [63:0] to_q16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x >>> 16;
    if (t > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (t < -64'sh8000_0000) return -64'sh8000_0000;
    return t;
  endfunction

  function automatic logic [31:0] weight_of(input logic signed [63:0] num,
                                            input logic signed [63:0] quad);
    logic [63:0] nm, qm, ip, rem;
    logic [64:0] sh;
    logic [63:0] mag;
    logic        neg;
    nm  = num[63] ? 64'd0 - num : num;
    qm  = quad[63] ? 64'd0 - quad : quad;
    neg = num[63] != quad[63];
    ip  = nm / qm;
    rem = nm % qm;
    if (ip >= 64'd65536) begin
      mag = 64'h1_0000_0000;
    end else begin
      mag = ip;
      for (int k = 0; k < 16; k++) begin
        sh  = {rem, 1'b0};
        rem = sh[63:0];
        mag = mag << 1;
        if (sh[64] || rem >= qm) begin
          rem = rem - qm;
          mag[0] = 1'b1;
        end
      end
    end
    if (!neg) begin
      return (mag > 64'h7FFF_FFFF) ? ilcws_pkg::POS_MAX : mag[31:0];
    end
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    mag = 64'd0 - mag;
    return mag[31:0];
  endfunction

  task automatic solve_pixel(input logic [25:0] tag);
    logic signed [63:0] num [MAX_BANDS];
    logic signed [63:0] quad, acc;
    ilcws_pkg::result_t r;
    int n;
    n = (bands_reg == 0) ? 1 : (bands_reg > MAX_BANDS) ? MAX_BANDS : int'(bands_reg);
    for (int c = 0; c < NUM_STOKES; c++) begin
      quad = 0;
      for (int b = 0; b < n; b++) begin
        acc = 0;
        for (int j = 0; j < n; j++) acc = add_sat(acc, mix_vec[j] * inv_cov[c][j][b]);
        num[b] = acc;
        quad = add_sat(quad, mix_vec[b] * to_q16(acc));
      end
      for (int b = 0; b < n; b++) begin
        r.weight_stokes = 2'(c);
        r.band          = 3'(b);
        r.divide_fault  = (quad == 0);
        r.weight        = (quad == 0) ? 32'd0 : weight_of(num[b], quad);
        r.pixel_tag_out = tag;
        r.last          = (c == ilcws_pkg::STOKES_U) && (b == n - 1);
        weights_due.push_back(r);
      end
    end
  endtask

  assign pending = weights_due.size();

  always @(posedge clk) begin
    ilcws_pkg::result_t got, want;
    if (!rst_n) begin
      errors    <= 0;
      bands_reg <= 4'd8;
      weights_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_BANDS)
        bands_reg <= cfg_pwdata[3:0];
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == ilcws_pkg::OP_MIX) begin
          mix_vec[in_ch.row] = 64'(in_ch.value);
        end else begin
          if (in_ch.stokes < NUM_STOKES)
            inv_cov[in_ch.stokes][in_ch.row][in_ch.col] = 64'(in_ch.value);
          if (in_ch.last_entry) solve_pixel(in_ch.pixel_tag);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.weight_stokes, out_ch.band, out_ch.weight, out_ch.divide_fault,
                out_ch.pixel_tag_out, out_ch.last};
        if (weights_due.size() == 0) begin
          $display("%0t: unexpected weight %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = weights_due.pop_front();
          if (got !== want) begin
            $display("%0t: weight mismatch expected %h got %h", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_ilc_weight_solver_core.sv @@
`timescale 1ns / 100ps
module tb_ilc_weight_solver_core;

  localparam int MAX_BANDS = 8;
  localparam int NUM_STOKES = 3;
  localparam int REG_BANDS = 0;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] STOKES_T = 2'd0;
  localparam logic [1:0] STOKES_Q = 2'd1;
  localparam logic [1:0] STOKES_BAD = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          errors, pending, send_idle, recv_idle, cycles;

  ilcws_in_if  in_ch();
  ilcws_out_if out_ch();

  ilc_weight_solver_core #(.MAX_BANDS(MAX_BANDS)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ilcws_checker #(.MAX_BANDS(MAX_BANDS)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ilc_weight_solver_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic write_reg(input int idx, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(4 * idx);
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send(input logic op, input logic [1:0] st, input logic [2:0] row,
                      input logic [2:0] col, input logic [31:0] val, input logic lst,
                      input logic [25:0] tag);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.stokes     <= st;
    in_ch.row        <= row;
    in_ch.col        <= col;
    in_ch.value      <= val;
    in_ch.last_entry <= lst;
    in_ch.pixel_tag  <= tag;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      2: return ($urandom_range(0, 1) != 0) ? ilcws_pkg::POS_MAX : ilcws_pkg::NEG_MAX;
      default: return 32'($urandom_range(0, 32'hFFFFF)) - 32'h80000;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 4) != 0) ? ilcws_pkg::OP_COV : ilcws_pkg::OP_MIX;
      send(op, 2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom), pick_value(),
           $urandom_range(0, 7) == 0, 26'($urandom));
    end
    send(ilcws_pkg::OP_COV, 2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
         pick_value(), 1'b1, 26'($urandom));
    drain();
  endtask

  initial begin
    cycles      = 0;
    rst_n       = 1'b0;
    send_idle   = 35;
    recv_idle   = 69;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_ch.valid = 1'b0;
    in_ch.operation  = ilcws_pkg::OP_MIX;
    in_ch.stokes     = '0;
    in_ch.row        = '0;
    in_ch.col        = '0;
    in_ch.value      = '0;
    in_ch.last_entry = 1'b0;
    in_ch.pixel_tag  = '0;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_BANDS, 32'd0);
    send(ilcws_pkg::OP_MIX, STOKES_T, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 26'h3FF_FFFF);
    send(ilcws_pkg::OP_COV, STOKES_T, 3'd0, 3'd0, ilcws_pkg::POS_MAX, 1'b0, 26'd0);
    send(ilcws_pkg::OP_COV, STOKES_Q, 3'd0, 3'd0, ilcws_pkg::NEG_MAX, 1'b0, 26'd0);
    send(ilcws_pkg::OP_COV, ilcws_pkg::STOKES_U, 3'd0, 3'd0, 32'd0, 1'b1, 26'h3FF_FFFF);
    send(ilcws_pkg::OP_MIX, STOKES_BAD, 3'd0, 3'd7, ilcws_pkg::NEG_MAX, 1'b1, 26'd5);
    send(ilcws_pkg::OP_COV, STOKES_BAD, 3'd7, 3'd7, 32'hDEAD_BEEF, 1'b1, 26'h155_5555);
    send(ilcws_pkg::OP_MIX, STOKES_T, 3'd0, 3'd0, 32'd0, 1'b0, 26'd1);
    send(ilcws_pkg::OP_COV, STOKES_T, 3'd0, 3'd0, 32'd5, 1'b1, 26'h2AA_AAAA);
    send(ilcws_pkg::OP_MIX, STOKES_T, 3'd0, 3'd0, 32'hFFFF_0000, 1'b0, 26'd2);
    send(ilcws_pkg::OP_COV, ilcws_pkg::STOKES_U, 3'd0, 3'd0, 32'hFFFE_0000, 1'b1, 26'd3);
    send(ilcws_pkg::OP_COV, STOKES_Q, 3'd0, 3'd0, 32'h0000_0001, 1'b1, 26'd4);
    drain();

    write_reg(REG_BANDS, 32'd15);
    for (int r = 0; r < MAX_BANDS; r++)
      send(ilcws_pkg::OP_MIX, 2'($urandom), 3'(r), 3'($urandom), pick_value(), 1'b0,
           26'($urandom));
    for (int s = 0; s < NUM_STOKES; s++)
      for (int r = 0; r < MAX_BANDS; r++)
        for (int c = 0; c < MAX_BANDS; c++)
          send(ilcws_pkg::OP_COV, 2'(s), 3'(r), 3'(c), pick_value(),
               s == NUM_STOKES - 1 && r == MAX_BANDS - 1 && c == MAX_BANDS - 1,
               26'($urandom));
    drain();

    send_idle = 69;
    recv_idle = 35;
    write_reg(REG_BANDS, 32'd2);
    random_phase(3);
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_BANDS, 32'd8);
    random_phase(3);
    write_reg(REG_BANDS, 32'd5);
    random_phase(3);

    if (errors == 0) begin
      $display("[ilc_weight_solver_core] OK");
    end else begin
      $display("[ilc_weight_solver_core] ERROR");
    end
    $finish;
  end

endmodule
